[rtl/motor_mode_supervisor_assert.svh]
// Assertion macros shared by the supervisor checker.
`ifndef MOTOR_MODE_SUPERVISOR_ASSERT_SVH
`define MOTOR_MODE_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("supervisor check failed");

// Next-cycle implication.
`define MMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("supervisor check failed");

`endif

[rtl/mms_pkg.sv]
// Types, codes and reset values for the motor mode supervisor.
`default_nettype none

package mms_pkg;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_DIRECT = 3'd1;
	localparam logic [2:0] MODE_CAL    = 3'd2;
	localparam logic [2:0] MODE_ENC    = 3'd3;
	localparam logic [2:0] MODE_ZERO   = 3'd4;
	localparam logic [2:0] MODE_RMEAS  = 3'd5;
	localparam logic [2:0] MODE_LMEAS  = 3'd6;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	localparam logic [2:0] FAULT_CLEAR = 3'd0;
	localparam logic [2:0] FAULT_CMD   = 3'd1;
	localparam logic [2:0] FAULT_ENC   = 3'd2;
	localparam logic [2:0] FAULT_OVER  = 3'd3;
	localparam logic [2:0] FAULT_UNDER = 3'd4;
	localparam logic [2:0] FAULT_TEMP  = 3'd5;

	localparam logic [2:0] REG_CMD_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_ENC_STALE   = 3'd1;
	localparam logic [2:0] REG_VBUS_MAX    = 3'd2;
	localparam logic [2:0] REG_VBUS_MIN    = 3'd3;
	localparam logic [2:0] REG_TEMP_CUTOFF = 3'd4;

	localparam logic [15:0] RST_CMD_TIMEOUT = 16'd1000;
	localparam logic [15:0] RST_ENC_STALE   = 16'd100;
	localparam logic [15:0] RST_VBUS_MAX    = 16'd6000;
	localparam logic [15:0] RST_VBUS_MIN    = 16'd0;
	localparam logic [11:0] RST_TEMP_CUTOFF = 12'd1000;

	typedef struct packed {
		logic [15:0] command_timeout_ticks;
		logic [15:0] encoder_stale_ticks;
		logic [15:0] bus_voltage_max;
		logic [15:0] bus_voltage_min;
		logic [11:0] temperature_cutoff;
	} cfg_t;

	typedef struct packed {
		logic        mode_valid;
		logic [2:0]  mode;
		logic        new_command;
		logic        encoder_update;
		logic [15:0] bus_voltage;
		logic [11:0] winding_temp;
		logic        cal_idle;
		logic        cal_postproc_pending;
		logic        measurement_done;
	} tick_t;

	typedef struct packed {
		logic [2:0] active_mode;
		logic       drive_enable;
		logic [2:0] fault_code;
		logic       control_step;
		logic       calibration_step;
		logic       zero_voltage_drive;
		logic       measurement_step;
		logic       start_calibration;
		logic       start_measurement;
		logic       save_request;
	} res_t;

	function automatic logic drives_power(input logic [2:0] m);
		return m inside {MODE_DIRECT, MODE_CAL, MODE_RMEAS, MODE_LMEAS};
	endfunction

endpackage

`default_nettype wire

[rtl/mms_cfg_regs.sv]
// Threshold and timeout registers of the supervisor.
`default_nettype none

module mms_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_wdata,
	output mms_pkg::cfg_t            cfg
);

	mms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_timeout_ticks <= mms_pkg::RST_CMD_TIMEOUT;
			cfg_q.encoder_stale_ticks   <= mms_pkg::RST_ENC_STALE;
			cfg_q.bus_voltage_max       <= mms_pkg::RST_VBUS_MAX;
			cfg_q.bus_voltage_min       <= mms_pkg::RST_VBUS_MIN;
			cfg_q.temperature_cutoff    <= mms_pkg::RST_TEMP_CUTOFF;
		end else if (cfg_write_en) begin
			case (cfg_index)
				mms_pkg::REG_CMD_TIMEOUT: cfg_q.command_timeout_ticks <= cfg_wdata;
				mms_pkg::REG_ENC_STALE:   cfg_q.encoder_stale_ticks   <= cfg_wdata;
				mms_pkg::REG_VBUS_MAX:    cfg_q.bus_voltage_max       <= cfg_wdata;
				mms_pkg::REG_VBUS_MIN:    cfg_q.bus_voltage_min       <= cfg_wdata;
				mms_pkg::REG_TEMP_CUTOFF: cfg_q.temperature_cutoff    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/mms_core.sv]
// Mode state, watchdog counters and the per-tick decision logic.
`default_nettype none

module mms_core #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire mms_pkg::tick_t tick,
	input  wire mms_pkg::cfg_t  cfg,
	output mms_pkg::res_t      res
);

	localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

	logic [2:0]               current_q;
	logic [2:0]               pending_q;
	logic [COUNTER_WIDTH-1:0] cmd_age_q;
	logic [COUNTER_WIDTH-1:0] enc_age_q;
	logic [2:0]               fault_q;
	logic                     drive_q;

	logic [2:0]               pend;
	logic [COUNTER_WIDTH-1:0] cage;
	logic [COUNTER_WIDTH-1:0] eage;
	logic [COUNTER_WIDTH-1:0] cage_inc;
	logic [COUNTER_WIDTH-1:0] eage_inc;
	logic [2:0]               fault;
	logic                     drive;
	logic [2:0]               trip;

	always_comb begin
		pend     = pending_q;
		cage     = tick.new_command ? '0 : cmd_age_q;
		eage     = tick.encoder_update ? '0 : enc_age_q;
		cage_inc = '0;
		eage_inc = '0;
		fault    = fault_q;
		drive    = drive_q;
		trip     = mms_pkg::FAULT_CLEAR;
		res      = '0;

		if (tick.mode_valid && tick.mode != mms_pkg::MODE_UNUSED) begin
			pend = tick.mode;
		end

		// transition: leave the old mode, enter the new one
		if (pend != current_q) begin
			if (mms_pkg::drives_power(current_q)) begin
				drive = 1'b0;
			end
			if (mms_pkg::drives_power(pend)) begin
				drive = 1'b1;
			end
			case (pend)
				mms_pkg::MODE_DIRECT: begin
					cage  = '0;
					eage  = '0;
					fault = mms_pkg::FAULT_CLEAR;
				end
				mms_pkg::MODE_CAL: res.start_calibration = 1'b1;
				mms_pkg::MODE_RMEAS, mms_pkg::MODE_LMEAS: res.start_measurement = 1'b1;
				default: ;
			endcase
		end

		res.active_mode = pend;

		case (pend)
			mms_pkg::MODE_DIRECT: begin
				// saturating increments of the ages, after any clearing above
				cage_inc = (cage == '1) ? cage : cage + 1'b1;
				eage_inc = (eage == '1) ? eage : eage + 1'b1;
				// encoder age advances only when the command check passes
				if (CMP_W'(cage_inc) > CMP_W'(cfg.command_timeout_ticks)) begin
					trip = mms_pkg::FAULT_CMD;
				end else if (CMP_W'(eage_inc) > CMP_W'(cfg.encoder_stale_ticks)) begin
					trip = mms_pkg::FAULT_ENC;
				end else if (tick.bus_voltage > cfg.bus_voltage_max) begin
					trip = mms_pkg::FAULT_OVER;
				end else if (tick.bus_voltage < cfg.bus_voltage_min) begin
					trip = mms_pkg::FAULT_UNDER;
				end else if ($signed(tick.winding_temp) > $signed(cfg.temperature_cutoff)) begin
					trip = mms_pkg::FAULT_TEMP;
				end
				if (trip != mms_pkg::FAULT_CMD) begin
					eage = eage_inc;
				end
				cage = cage_inc;
				if (trip != mms_pkg::FAULT_CLEAR) begin
					fault = trip;
					pend  = mms_pkg::MODE_IDLE;
				end else begin
					res.control_step = 1'b1;
				end
			end
			mms_pkg::MODE_CAL: begin
				res.calibration_step = !tick.cal_idle && !tick.cal_postproc_pending;
				if (tick.cal_idle) begin
					pend = mms_pkg::MODE_ENC;
				end
			end
			mms_pkg::MODE_ENC, mms_pkg::MODE_ZERO: res.zero_voltage_drive = 1'b1;
			mms_pkg::MODE_RMEAS, mms_pkg::MODE_LMEAS: begin
				res.measurement_step = 1'b1;
				if (tick.measurement_done) begin
					res.save_request = 1'b1;
					pend = mms_pkg::MODE_IDLE;
				end
			end
			default: ;
		endcase

		res.drive_enable = drive;
		res.fault_code   = fault;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= mms_pkg::MODE_IDLE;
			pending_q <= mms_pkg::MODE_IDLE;
			cmd_age_q <= '0;
			enc_age_q <= '0;
			fault_q   <= mms_pkg::FAULT_CLEAR;
			drive_q   <= 1'b0;
		end else if (step) begin
			current_q <= res.active_mode;
			pending_q <= pend;
			cmd_age_q <= cage;
			enc_age_q <= eage;
			fault_q   <= fault;
			drive_q   <= drive;
		end
	end

endmodule

`default_nettype wire

[rtl/motor_mode_supervisor.sv]
// Path: an accepted input beat is held in the input register, and its result is registered
// in the result register. Throughput: one tick per cycle while the output is taken; a
// stalled output holds one result while one more input beat waits in the input register.
// Reset: asynchronous, active low; the mode returns to idle, drive off, no fault,
// ages zero and all thresholds at their default values.
`default_nettype none

module motor_mode_supervisor #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_write_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	// tick input channel
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        mode_valid,
	input  wire logic [2:0]  mode,
	input  wire logic        new_command,
	input  wire logic        encoder_update,
	input  wire logic [15:0] bus_voltage,
	input  wire logic signed [11:0] winding_temp,
	input  wire logic        cal_idle,
	input  wire logic        cal_postproc_pending,
	input  wire logic        measurement_done,
	// result output channel
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  active_mode,
	output      logic        drive_enable,
	output      logic [2:0]  fault_code,
	output      logic        control_step,
	output      logic        calibration_step,
	output      logic        zero_voltage_drive,
	output      logic        measurement_step,
	output      logic        start_calibration,
	output      logic        start_measurement,
	output      logic        save_request
);

	mms_pkg::cfg_t  cfg;
	mms_pkg::tick_t tick_s1;
	logic           valid_s1;
	mms_pkg::res_t  res;
	mms_pkg::res_t  res_q;
	logic           out_valid_q;
	logic           advance;
	logic           in_take;

	// Threshold registers; write them only while the block is idle.
	mms_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cfg          (cfg)
	);

	// Advance the held tick into the result register whenever that register is
	// empty or its beat is taken this cycle. The mode state moves with it, so a
	// tick changes the state exactly once.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	// The input register frees up on the same edge it drains.
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1.mode_valid           <= mode_valid;
			tick_s1.mode                 <= mode;
			tick_s1.new_command          <= new_command;
			tick_s1.encoder_update       <= encoder_update;
			tick_s1.bus_voltage          <= bus_voltage;
			tick_s1.winding_temp         <= winding_temp;
			tick_s1.cal_idle             <= cal_idle;
			tick_s1.cal_postproc_pending <= cal_postproc_pending;
			tick_s1.measurement_done     <= measurement_done;
		end
	end

	// Decision logic and mode state; commits on advance.
	mms_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register: hold the beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign active_mode        = res_q.active_mode;
	assign drive_enable       = res_q.drive_enable;
	assign fault_code         = res_q.fault_code;
	assign control_step       = res_q.control_step;
	assign calibration_step   = res_q.calibration_step;
	assign zero_voltage_drive = res_q.zero_voltage_drive;
	assign measurement_step   = res_q.measurement_step;
	assign start_calibration  = res_q.start_calibration;
	assign start_measurement  = res_q.start_measurement;
	assign save_request       = res_q.save_request;

endmodule

`default_nettype wire

[rtl/mms_checker.sv]
// Port-level checks for the motor mode supervisor, bound to the top level.
`default_nettype none
`include "motor_mode_supervisor_assert.svh"

module mms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] active_mode,
	input wire logic       drive_enable,
	input wire logic [2:0] fault_code,
	input wire logic       control_step,
	input wire logic       measurement_step,
	input wire logic       save_request
);

	// power stage follows the mode in force
	`MMS_ASSERT_IMP(a_drive_follows_mode, clk, arst_n, out_valid, drive_enable == mms_pkg::drives_power(active_mode))

	// control runs only in direct drive
	`MMS_ASSERT_IMP(a_ctl_in_direct, clk, arst_n, out_valid && control_step, active_mode == mms_pkg::MODE_DIRECT)

	// a save comes only out of a running measurement
	`MMS_ASSERT_IMP(a_save_in_meas, clk, arst_n, out_valid && save_request, measurement_step && (active_mode == mms_pkg::MODE_RMEAS || active_mode == mms_pkg::MODE_LMEAS))

	// a stalled result beat holds
	`MMS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(active_mode) && $stable(fault_code))

endmodule

bind motor_mode_supervisor mms_checker u_mms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.active_mode      (active_mode),
	.drive_enable     (drive_enable),
	.fault_code       (fault_code),
	.control_step     (control_step),
	.measurement_step (measurement_step),
	.save_request     (save_request)
);

`default_nettype wire

[bench/tb_motor_mode_supervisor.sv]
// Self-checking testbench for the motor mode supervisor: directed and random ticks.
module tb_motor_mode_supervisor;
	import mms_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 9;
	localparam int CNT_W          = 16;
	localparam int DRAIN_CYCLES   = 4;        // margin for the pipeline to empty out
	localparam int HOLD_CYCLES    = 200;      // long output hold-off for the pressure test
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int REG_SLOTS      = 8;        // cfg_index is three bits wide
	localparam int TEMP_LOW       = -400;
	localparam int TEMP_SPAN      = 2400;     // TEMP_LOW up to 2000

	// Clock, reset and configuration port.
	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [2:0]  cfg_index    = REG_CMD_TIMEOUT;
	logic [15:0] cfg_wdata    = '0;

	// Tick input channel.
	logic               in_valid             = 1'b0;
	logic               in_ready;
	logic               mode_valid           = 1'b0;
	logic [2:0]         mode                 = MODE_IDLE;
	logic               new_command          = 1'b0;
	logic               encoder_update       = 1'b0;
	logic [15:0]        bus_voltage          = '0;
	logic signed [11:0] winding_temp         = '0;
	logic               cal_idle             = 1'b0;
	logic               cal_postproc_pending = 1'b0;
	logic               measurement_done     = 1'b0;

	// Status output channel.
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] active_mode;
	logic       drive_enable;
	logic [2:0] fault_code;
	logic       control_step;
	logic       calibration_step;
	logic       zero_voltage_drive;
	logic       measurement_step;
	logic       start_calibration;
	logic       start_measurement;
	logic       save_request;

	// Idling knobs, in percent, and the hold-off request for the receiver.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_start    = 1'b0;
	int hold_left     = 0;

	int mismatches = 0;

	// Shadow of the supervisor: thresholds, modes, watchdog ages, fault latch, power stage.
	cfg_t thr = {RST_CMD_TIMEOUT, RST_ENC_STALE, RST_VBUS_MAX, RST_VBUS_MIN, RST_TEMP_CUTOFF};
	logic [2:0]       run_mode    = MODE_IDLE;
	logic [2:0]       want_mode   = MODE_IDLE;
	logic [CNT_W-1:0] cmd_age     = '0;
	logic [CNT_W-1:0] enc_age     = '0;
	logic [2:0]       fault_latch = FAULT_CLEAR;
	logic             drive_on    = 1'b0;

	// Status beats predicted at input acceptance, oldest first.
	res_t expected_status[$];

	motor_mode_supervisor #(
		.COUNTER_WIDTH(CNT_W)
	) u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write_en        (cfg_write_en),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.mode_valid          (mode_valid),
		.mode                (mode),
		.new_command         (new_command),
		.encoder_update      (encoder_update),
		.bus_voltage         (bus_voltage),
		.winding_temp        (winding_temp),
		.cal_idle            (cal_idle),
		.cal_postproc_pending(cal_postproc_pending),
		.measurement_done    (measurement_done),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.active_mode         (active_mode),
		.drive_enable        (drive_enable),
		.fault_code          (fault_code),
		.control_step        (control_step),
		.calibration_step    (calibration_step),
		.zero_voltage_drive  (zero_voltage_drive),
		.measurement_step    (measurement_step),
		.start_calibration   (start_calibration),
		.start_measurement   (start_measurement),
		.save_request        (save_request)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Modes that keep the power stage on while they are in force.
	function automatic logic powers_stage(input logic [2:0] m);
		case (m)
			MODE_DIRECT, MODE_CAL, MODE_RMEAS, MODE_LMEAS: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Advance the shadow by one control tick and return the status it produces.
	// Order within a tick: take the request, clear ages, switch mode, then do the mode's work.
	function automatic res_t advance_supervisor(input tick_t t);
		res_t r;
		logic [2:0] trip;
		r = '0;
		trip = FAULT_CLEAR;
		// Code seven is not a mode; a request for it leaves the pending mode alone.
		if (t.mode_valid && t.mode != MODE_UNUSED)
			want_mode = t.mode;
		if (t.new_command)
			cmd_age = '0;
		if (t.encoder_update)
			enc_age = '0;
		if (want_mode != run_mode) begin
			// Drop power on leaving a powered mode, raise it on entering one.
			if (powers_stage(run_mode))
				drive_on = 1'b0;
			run_mode = want_mode;
			if (powers_stage(run_mode))
				drive_on = 1'b1;
			case (run_mode)
				MODE_DIRECT: begin
					cmd_age = '0;
					enc_age = '0;
					fault_latch = FAULT_CLEAR;
				end
				MODE_CAL: r.start_calibration = 1'b1;
				MODE_RMEAS, MODE_LMEAS: r.start_measurement = 1'b1;
				default: ;
			endcase
		end
		case (run_mode)
			MODE_DIRECT: begin
				// Watchdog: the encoder age only moves when the command age passes.
				if (cmd_age != '1)
					cmd_age = cmd_age + 1'b1;
				if (cmd_age > thr.command_timeout_ticks) begin
					trip = FAULT_CMD;
				end else begin
					if (enc_age != '1)
						enc_age = enc_age + 1'b1;
					if (enc_age > thr.encoder_stale_ticks)
						trip = FAULT_ENC;
					else if (t.bus_voltage > thr.bus_voltage_max)
						trip = FAULT_OVER;
					else if (t.bus_voltage < thr.bus_voltage_min)
						trip = FAULT_UNDER;
					else if ($signed(t.winding_temp) > $signed(thr.temperature_cutoff))
						trip = FAULT_TEMP;
				end
				// A trip latches its code and heads back to idle on the next tick.
				if (trip != FAULT_CLEAR) begin
					fault_latch = trip;
					want_mode = MODE_IDLE;
				end else begin
					r.control_step = 1'b1;
				end
			end
			MODE_CAL: begin
				if (!t.cal_idle && !t.cal_postproc_pending)
					r.calibration_step = 1'b1;
				if (t.cal_idle && want_mode == MODE_CAL)
					want_mode = MODE_ENC;
			end
			MODE_ENC, MODE_ZERO: r.zero_voltage_drive = 1'b1;
			MODE_RMEAS, MODE_LMEAS: begin
				r.measurement_step = 1'b1;
				if (t.measurement_done) begin
					r.save_request = 1'b1;
					want_mode = MODE_IDLE;
				end
			end
			default: ;
		endcase
		r.active_mode = run_mode;
		r.drive_enable = drive_on;
		r.fault_code = fault_latch;
		return r;
	endfunction

	// Offer one tick beat, after a random gap, and predict its status on acceptance.
	// Valid stays high on return so back-to-back beats never drop it within a step.
	task automatic send_tick(input tick_t t);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{mode_valid, mode, new_command, encoder_update, bus_voltage, winding_temp,
			cal_idle, cal_postproc_pending, measurement_done} <= t;
		do @(posedge clk); while (!in_ready);
		expected_status.push_back(advance_supervisor(t));
	endtask

	// Drop valid, wait for every predicted beat, then let the pipeline empty out.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Pulse one register write and mirror it into the shadow thresholds.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_CMD_TIMEOUT: thr.command_timeout_ticks = val;
			REG_ENC_STALE:   thr.encoder_stale_ticks = val;
			REG_VBUS_MAX:    thr.bus_voltage_max = val;
			REG_VBUS_MIN:    thr.bus_voltage_min = val;
			REG_TEMP_CUTOFF: thr.temperature_cutoff = val[11:0];
			default: ;
		endcase
	endtask

	// Quiesce the block and load a full set of thresholds.
	task automatic set_thresholds(input int cmd, input int enc, input int vmax,
		input int vmin, input int temp);
		settle_block();
		write_reg(REG_CMD_TIMEOUT, 16'(cmd));
		write_reg(REG_ENC_STALE, 16'(enc));
		write_reg(REG_VBUS_MAX, 16'(vmax));
		write_reg(REG_VBUS_MIN, 16'(vmin));
		write_reg(REG_TEMP_CUTOFF, 16'(temp));
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	function automatic tick_t tick_of(input bit req, input logic [2:0] m, input bit cmd,
		input bit enc, input int vbus, input int temp, input bit cidle, input bit cpost,
		input bit mdone);
		return {req, m, cmd, enc, 16'(vbus), 12'(temp), cidle, cpost, mdone};
	endfunction

	// Build one tick of a mode session: a request on the first tick, then mostly
	// plausible sensor data, with a slice of raw noise mixed in.
	function automatic tick_t compose_tick(input logic [2:0] goal, input bit first,
		input int cmd_pct, input int enc_pct);
		tick_t t;
		logic [63:0] noise;
		int temp_top;
		noise = {$urandom, $urandom};
		temp_top = $signed(thr.temperature_cutoff) - TEMP_LOW;
		if ($urandom_range(99) < 12) begin
			t = noise[$bits(tick_t)-1:0];
			t.winding_temp = 12'($urandom_range(TEMP_SPAN) + TEMP_LOW);
		end else begin
			t.mode_valid = first || ($urandom_range(99) < 3);
			t.mode = first ? goal : 3'($urandom_range(MODE_LMEAS));
			t.new_command = $urandom_range(99) < cmd_pct;
			t.encoder_update = $urandom_range(99) < enc_pct;
			if ($urandom_range(99) < 92)
				t.bus_voltage = 16'($urandom_range(thr.bus_voltage_max, thr.bus_voltage_min));
			else
				t.bus_voltage = noise[63:48];
			if ($urandom_range(99) < 95 && temp_top >= 0)
				t.winding_temp = 12'($urandom_range(temp_top) + TEMP_LOW);
			else
				t.winding_temp = 12'($urandom_range(TEMP_SPAN) + TEMP_LOW);
			t.cal_idle = $urandom_range(99) < 10;
			t.cal_postproc_pending = $urandom_range(99) < 15;
			t.measurement_done = $urandom_range(99) < 8;
		end
		return t;
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(2))
			0: return 95;
			1: return 60;
			default: return 8;
		endcase
	endfunction

	// Run back-to-back mode sessions: pick a mode, request it, then stay a while.
	task automatic run_sessions(input int count);
		int left;
		int span;
		int cmd_pct;
		int enc_pct;
		logic [2:0] goal;
		left = count;
		while (left > 0) begin
			goal = ($urandom_range(19) == 0) ? MODE_UNUSED : 3'($urandom_range(MODE_LMEAS));
			cmd_pct = pick_rate();
			enc_pct = pick_rate();
			span = $urandom_range(40, 2);
			for (int k = 0; k < span && left > 0; k++) begin
				send_tick(compose_tick(goal, k == 0, cmd_pct, enc_pct));
				left--;
			end
		end
	endtask

	// Reset thresholds: limits exactly at the defaults pass, one count over trips.
	task automatic test_defaults_after_reset();
		set_idling(0, 0);
		send_tick(tick_of(1, MODE_UNUSED, 0, 0, 65535, 2000, 1, 1, 1));
		send_tick(tick_of(1, MODE_DIRECT, 1, 1, 6000, 1000, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 1, 6001, 0, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Walk every mode and every fault with tight thresholds.
	task automatic test_directed_modes();
		set_thresholds(2, 1, 5000, 100, 500);
		// Writes past the last register must leave the thresholds alone.
		for (int i = REG_TEMP_CUTOFF + 1; i < REG_SLOTS; i++)
			write_reg(3'(i), 16'($urandom));
		send_tick(tick_of(1, MODE_DIRECT, 1, 1, 1000, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_UNUSED, 0, 1, 1000, -400, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 1, 1000, 0, 0, 0, 0));      // command timeout
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 1000, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_DIRECT, 0, 0, 1000, 0, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 1, 0, 1000, 0, 0, 0, 0));      // encoder stale
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 1000, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_DIRECT, 1, 1, 5001, 0, 0, 0, 0));    // overvoltage
		// Re-request direct drive before the exit lands: stays in mode, fault rewritten.
		send_tick(tick_of(1, MODE_DIRECT, 1, 1, 99, 0, 0, 0, 0));      // undervoltage
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 1000, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_DIRECT, 1, 1, 1000, 501, 0, 0, 0));  // overtemperature
		// Calibration: post-processing holds the step, then the sequencer goes idle.
		send_tick(tick_of(1, MODE_CAL, 0, 0, 0, 2000, 0, 1, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 1, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_ZERO, 0, 0, 0, 0, 0, 0, 0));
		// Measurements: one finishes on its entry tick, the other a tick later.
		send_tick(tick_of(1, MODE_RMEAS, 0, 0, 0, 0, 0, 0, 1));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(1, MODE_LMEAS, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 1));
		send_tick(tick_of(0, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Hold the output off for a long stretch while ticks keep coming, so the
	// block fills and drops in_ready; then pause the sender until all beats are back.
	task automatic test_output_backpressure();
		set_thresholds(40, 20, 7000, 500, 900);
		set_idling(0, 0);
		hold_start = 1'b1;
		run_sessions(40);
		settle_block();
	endtask

	// Extreme thresholds: one set trips on every direct-drive tick, the other never trips.
	task automatic test_threshold_extremes();
		set_idling(7, 7);
		set_thresholds(0, 0, 0, 65535, TEMP_LOW);
		run_sessions(80);
		set_thresholds(65534, 65534, 65535, 0, 2000);
		run_sessions(80);
	endtask

	// Random sessions under each idling profile, each with fresh thresholds.
	task automatic test_random_traffic();
		int send_pcts[4];
		int recv_pcts[4];
		send_pcts = '{0, 71, 0, 7};
		recv_pcts = '{0, 0, 71, 7};
		for (int p = 0; p < 4; p++) begin
			set_thresholds($urandom_range(60), $urandom_range(30), $urandom_range(65535, 3000),
				$urandom_range(2500), $urandom_range(TEMP_SPAN) + TEMP_LOW);
			set_idling(send_pcts[p], recv_pcts[p]);
			run_sessions(330);
		end
	endtask

	// Receiver: count down a requested hold-off, otherwise stall at the set rate.
	always @(posedge clk) begin
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted status beat with the oldest prediction.
	always @(posedge clk) begin : check_status
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {active_mode, drive_enable, fault_code, control_step, calibration_step,
				zero_voltage_drive, measurement_step, start_calibration, start_measurement,
				save_request};
			if (expected_status.size() == 0) begin
				$display("%0t: status beat with nothing expected, got %h", $time, got);
				mismatches++;
			end else begin
				want = expected_status.pop_front();
				check_field("active_mode", want.active_mode, got.active_mode);
				check_field("drive_enable", want.drive_enable, got.drive_enable);
				check_field("fault_code", want.fault_code, got.fault_code);
				check_field("control_step", want.control_step, got.control_step);
				check_field("calibration_step", want.calibration_step, got.calibration_step);
				check_field("zero_voltage_drive", want.zero_voltage_drive, got.zero_voltage_drive);
				check_field("measurement_step", want.measurement_step, got.measurement_step);
				check_field("start_calibration", want.start_calibration, got.start_calibration);
				check_field("start_measurement", want.start_measurement, got.start_measurement);
				check_field("save_request", want.save_request, got.save_request);
			end
		end
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_after_reset();
		test_directed_modes();
		test_output_backpressure();
		test_threshold_extremes();
		test_random_traffic();
		settle_block();
		if (mismatches == 0 && expected_status.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/mms_pkg.sv
rtl/mms_cfg_regs.sv
rtl/mms_core.sv
rtl/motor_mode_supervisor.sv
rtl/mms_checker.sv
bench/tb_motor_mode_supervisor.sv
